// File: rtl/sha256_byte_stream_hasher_core_defines.svh
// Assertion macros for the SHA-256 byte stream hasher.
// Used by the top level; the checks drop out when SYNTHESIS is defined.
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and held off during reset.
`define SHA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 core check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 core check failed");

`else

`define SHA_ASSERT_NOW(lbl, ante, cons)
`define SHA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/sha256bsh_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// Depends on nothing; used by the controller, the datapath and the top level.
package sha256bsh_pkg;

    localparam int FILL_W     = 7;
    localparam int ROUND_W    = 6;
    localparam int IDX_W      = 3;
    localparam int WORD_W     = 32;
    localparam int HASH_WORDS = 8;
    localparam int BLOCK_W    = 512;
    localparam int LEN_W      = 64;
    localparam int BYTE_W     = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [FILL_W-1:0]  FILL_FULL = 7'd64;
    localparam logic [FILL_W-1:0]  FILL_LAST = 7'd63;
    localparam logic [FILL_W-1:0]  FILL_LEN  = 7'd56;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
    localparam logic [IDX_W-1:0]   IDX_LAST   = 3'd7;
    localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;
    localparam logic [LEN_W-1:0]   BLOCK_BITS = 64'd512;

    // Item kinds carried on the input tuser bit.
    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } state_t;

    // What follows a compression.
    typedef enum logic [1:0] {
        MODE_ABSORB,
        MODE_PAD,
        MODE_FINAL
    } mode_t;

    // Source of the byte shifted into the block buffer.
    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } bsel_t;

    typedef struct packed {
        logic  shift_en;
        bsel_t bsel;
        logic  add_tail;
        logic  comp_load;
        logic  round_en;
        logic  fold;
        logic  count_block;
        logic  out_next;
        logic  reinit;
    } cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              round_last;
        logic              out_last;
    } stat_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: rtl/sha256bsh_ctrl.sv
// Controller state machine for the SHA-256 byte stream hasher.
// Depends on sha256bsh_pkg; drives the datapath by commands and reads its status.
module sha256bsh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_func,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  sha256bsh_pkg::stat_t stat,
    output sha256bsh_pkg::cmd_t  cmd
);
    import sha256bsh_pkg::*;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    // State and follow-on mode registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_ABSORB;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        cmd.bsel   = BSEL_DATA;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.shift_en = 1'b1;
                    if (in_func == FUNC_ABSORB)
                    begin
                        cmd.bsel = BSEL_DATA;
                        // The byte that completes a block starts its compression.
                        if (stat.fill == FILL_LAST)
                        begin
                            cmd.comp_load = 1'b1;
                            mode_next     = MODE_ABSORB;
                            state_next    = ST_COMP;
                        end
                    end
                    else
                    begin
                        cmd.bsel     = BSEL_PAD;
                        cmd.add_tail = 1'b1;
                        state_next   = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // A full block after the pad byte is compressed before the length goes in.
                if (stat.fill == FILL_FULL)
                begin
                    cmd.comp_load = 1'b1;
                    mode_next     = MODE_PAD;
                    state_next    = ST_COMP;
                end
                else if (stat.fill == FILL_LEN)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.bsel     = BSEL_ZERO;
                end
            end
            ST_LEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.bsel     = BSEL_LEN;
                if (stat.fill == FILL_LAST)
                begin
                    cmd.comp_load = 1'b1;
                    mode_next     = MODE_FINAL;
                    state_next    = ST_COMP;
                end
            end
            ST_COMP:
            begin
                cmd.round_en = 1'b1;
                if (stat.round_last)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold        = 1'b1;
                cmd.count_block = (mode_reg == MODE_ABSORB);
                unique case (mode_reg)
                    MODE_ABSORB: state_next = ST_IDLE;
                    MODE_PAD:    state_next = ST_PAD;
                    MODE_FINAL:  state_next = ST_OUT;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.out_next = 1'b1;
                    // After the last word the hash words, bit count, fill and word index return to their reset values.
                    if (stat.out_last)
                    begin
                        cmd.reinit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sha256bsh_dp.sv
// Datapath of the SHA-256 byte stream hasher: block shift buffer, message
// schedule, round logic, hash words and bit count. Depends on sha256bsh_pkg.
module sha256bsh_dp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  sha256bsh_pkg::cmd_t                      cmd,
    output sha256bsh_pkg::stat_t                     stat,
    input  logic [sha256bsh_pkg::BYTE_W-1:0]         data_byte,
    output logic [sha256bsh_pkg::WORD_W-1:0]         digest_word,
    output logic [sha256bsh_pkg::IDX_W-1:0]          word_index
);
    import sha256bsh_pkg::*;

    logic [BLOCK_W-1:0] blk_reg, blk_next;
    logic [WORD_W-1:0]  v_reg [HASH_WORDS];
    logic [WORD_W-1:0]  v_next [HASH_WORDS];
    logic [WORD_W-1:0]  hash_reg [HASH_WORDS];
    logic [WORD_W-1:0]  hash_next [HASH_WORDS];
    logic [LEN_W-1:0]   msg_bits_reg, msg_bits_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    logic [BYTE_W-1:0]  in_byte;
    logic [WORD_W-1:0]  w0, w1, w9, w14, w_new;
    logic [WORD_W-1:0]  t1, t2, choose, major;

    // Byte source for the block buffer.
    always_comb
    begin
        unique case (cmd.bsel)
            BSEL_DATA: in_byte = data_byte;
            BSEL_PAD:  in_byte = PAD_BYTE;
            BSEL_ZERO: in_byte = '0;
            BSEL_LEN:  in_byte = msg_bits_reg[LEN_W-1 -: BYTE_W];
            default:   in_byte = '0;
        endcase
    end

    // Schedule window taps: the oldest word sits in the top bits.
    assign w0  = blk_reg[BLOCK_W-1 -: WORD_W];
    assign w1  = blk_reg[BLOCK_W-1-WORD_W -: WORD_W];
    assign w9  = blk_reg[BLOCK_W-1-9*WORD_W -: WORD_W];
    assign w14 = blk_reg[BLOCK_W-1-14*WORD_W -: WORD_W];
    assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

    // One compression round.
    assign choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1 = v_reg[7] + big_sigma1(v_reg[4]) + choose + ROUND_K[round_reg] + w0;
    assign t2 = big_sigma0(v_reg[0]) + major;

    // Next-value logic.
    always_comb
    begin
        blk_next      = blk_reg;
        v_next        = v_reg;
        hash_next     = hash_reg;
        msg_bits_next = msg_bits_reg;
        fill_next     = fill_reg;
        round_next    = round_reg;
        idx_next      = idx_reg;

        if (cmd.shift_en)
        begin
            blk_next  = {blk_reg[BLOCK_W-BYTE_W-1:0], in_byte};
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.round_en)
        begin
            blk_next = {blk_reg[BLOCK_W-WORD_W-1:0], w_new};
        end

        if (cmd.comp_load)
        begin
            v_next = hash_reg;
        end
        else if (cmd.round_en)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end

        if (cmd.round_en)
        begin
            round_next = round_reg + 1'b1;
        end

        // Bit count: tail bytes at finish, length bytes shifted out, whole blocks.
        if (cmd.add_tail)
        begin
            msg_bits_next = msg_bits_reg + {{(LEN_W-FILL_W-2){1'b0}}, fill_reg[FILL_W-2:0], 3'b000};
        end
        else if (cmd.shift_en && (cmd.bsel == BSEL_LEN))
        begin
            msg_bits_next = {msg_bits_reg[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        end
        else if (cmd.fold && cmd.count_block)
        begin
            msg_bits_next = msg_bits_reg + BLOCK_BITS;
        end

        if (cmd.fold)
        begin
            fill_next = '0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                hash_next[i] = hash_reg[i] + v_reg[i];
            end
        end

        if (cmd.out_next)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.reinit)
        begin
            hash_next     = INIT_HASH;
            msg_bits_next = '0;
            fill_next     = '0;
            idx_next      = '0;
        end
    end

    // Hash state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg     <= INIT_HASH;
            msg_bits_reg <= '0;
            fill_reg     <= '0;
            round_reg    <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            hash_reg     <= hash_next;
            msg_bits_reg <= msg_bits_next;
            fill_reg     <= fill_next;
            round_reg    <= round_next;
            idx_reg      <= idx_next;
        end
    end

    // Block buffer and working variables carry no reset.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        v_reg   <= v_next;
    end

    assign stat.fill       = fill_reg;
    assign stat.round_last = (round_reg == ROUND_LAST);
    assign stat.out_last   = (idx_reg == IDX_LAST);

    assign digest_word = hash_reg[idx_reg];
    assign word_index  = idx_reg;

endmodule

// File: rtl/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte stream hasher: controller, datapath and checks.
// Depends on sha256bsh_pkg, sha256bsh_ctrl, sha256bsh_dp and the defines header.
//
//  Channel   Direction  tdata                          tuser / tlast
//  s_axis    in         [7:0] data_byte                tuser: func (0 absorb, 1 finish)
//  m_axis    out        [31:0] digest_word, [34:32]    tlast: last_word
//                       word_index, [39:35] zero
//
// An absorbed byte is taken while s_axis_tready is high; the 64th byte of a block then
// holds s_axis_tready low (64 rounds on the one round unit, one fold).
// A finish shifts in the pad byte, then the zero bytes (up to 63), with one pause before
// the eight length bytes and one before an extra block, and runs one or two compressions;
// eight words follow, one per accepted request, and a stalled m_axis holds
// the word with s_axis_tready low. Reset restores the initial hash words and clears counts.
`include "sha256_byte_stream_hasher_core_defines.svh"

module sha256_byte_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);
    import sha256bsh_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic [WORD_W-1:0]  digest_word;
    logic [IDX_W-1:0]   word_index;

    sha256bsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sha256bsh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .data_byte   (s_axis_tdata),
        .digest_word (digest_word),
        .word_index  (word_index)
    );

    // Output word packing.
    assign m_axis_tdata = {{(OUT_TDATA_W-WORD_W-IDX_W){1'b0}}, word_index, digest_word};
    assign m_axis_tlast = stat.out_last;

    // Input and output never open together.
    `SHA_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid)
    // After the final digest word the block is ready for a new message.
    `SHA_ASSERT_NEXT(a_idle_after_digest, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready && !m_axis_tvalid)
    // Compression only starts on a complete block.
    `SHA_ASSERT_NOW(a_load_on_full, cmd.comp_load, (stat.fill == FILL_FULL) || (cmd.shift_en && (stat.fill == FILL_LAST)))
    // Rounds run without a break until the last one.
    `SHA_ASSERT_NEXT(a_rounds_run, cmd.round_en && !stat.round_last, cmd.round_en)

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the SHA-256 byte stream hasher core.
// Drives byte and finish requests with random idling and checks each digest word against
// a SHA-256 predictor of its own. Depends only on sha256bsh_pkg and the core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sha256bsh_pkg::*;

    localparam int IDLE_PCT     = 38;
    localparam int QUIET_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 330;
    localparam int CALM_FROM    = 150;
    localparam int CALM_TO      = 250;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } byte_request_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    // Clock, reset and the block's ports, all known from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = FUNC_ABSORB;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Stimulus and scoreboard state.
    byte_request_t pending_q[$];
    digest_word_t  digest_q[$];
    int            total_items = 0;
    int            sent_items = 0;
    int            accepted_items = 0;
    int            bytes_absorbed = 0;
    int            messages_hashed = 0;
    int            words_checked = 0;
    int            fail_count = 0;
    int            quiet_cycles = 0;
    logic          s_taken = 1'b0;
    logic          calm;

    // Predictor state: chaining words, block buffer, fill level and bit count.
    logic [31:0] hash_acc [8];
    logic [7:0]  block_buf [64];
    int          block_fill;
    logic [63:0] message_bits;

    sha256_byte_stream_hasher_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Neither side idles while this window of requests is being sent.
    assign calm = (sent_items >= CALM_FROM) && (sent_items < CALM_TO);

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++)
            hash_acc[i] = SHA_IV[i];
        for (int i = 0; i < 64; i++)
            block_buf[i] = 8'h00;
        block_fill = 0;
        message_bits = 64'd0;
    endfunction

    // One 64-round compression of the block buffer into the chaining words.
    function automatic void hash_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++)
            v[i] = hash_acc[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_acc[i] = hash_acc[i] + v[i];
    endfunction

    function automatic void hash_absorb(input logic [7:0] b);
        block_buf[block_fill] = b;
        block_fill++;
        if (block_fill == 64)
        begin
            hash_compress();
            message_bits = message_bits + 64'd512;
            block_fill = 0;
        end
    endfunction

    // Pad, append the length, compress and queue the eight digest words.
    function automatic void hash_finish();
        int pos;
        digest_word_t dw;
        pos = block_fill;
        message_bits = message_bits + 64'(pos * 8);
        block_buf[pos] = 8'h80;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                block_buf[pos] = 8'h00;
                pos++;
            end
            hash_compress();
            pos = 0;
        end
        while (pos < 56)
        begin
            block_buf[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            block_buf[56+i] = message_bits[63 - 8*i -: 8];
        hash_compress();
        for (int i = 0; i < 8; i++)
        begin
            dw.value = hash_acc[i];
            dw.index = 3'(i);
            dw.last  = (i == 7);
            digest_q.push_back(dw);
        end
        hash_restart();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        byte_request_t req;
        req.func = FUNC_ABSORB;
        req.data_byte = b;
        pending_q.push_back(req);
        total_items++;
    endtask

    // The byte of a finish request is ignored by the block, so it carries noise.
    task automatic queue_finish();
        byte_request_t req;
        req.func = FUNC_FINISH;
        req.data_byte = 8'($urandom_range(0, 255));
        pending_q.push_back(req);
        total_items++;
    endtask

    task automatic queue_message(input int len);
        for (int i = 0; i < len; i++)
            queue_byte(8'($urandom_range(0, 255)));
        queue_finish();
    endtask

    // Driver: presents the next pending request once the previous one has been taken.
    always @(negedge clk)
    begin : drive_requests
        byte_request_t req;
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_taken)
            begin
                if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    req = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= req.func;
                    s_axis_tdata  <= req.data_byte;
                    sent_items    <= sent_items + 1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: predicts on every accepted request and checks every accepted digest word.
    always @(posedge clk)
    begin : watch_streams
        digest_word_t want;
        s_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                accepted_items++;
                if (s_axis_tuser == FUNC_FINISH)
                begin
                    hash_finish();
                    messages_hashed++;
                end
                else
                begin
                    hash_absorb(s_axis_tdata);
                    bytes_absorbed++;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                words_checked++;
                if (digest_q.size() == 0)
                begin
                    report_mismatch("unexpected digest word", m_axis_tdata[31:0], 32'd0);
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.value)
                        report_mismatch("digest_word", m_axis_tdata[31:0], want.value);
                    if (m_axis_tdata[34:32] !== want.index)
                        report_mismatch("word_index", 32'(m_axis_tdata[34:32]),
                                        32'(want.index));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_word", 32'(m_axis_tlast), 32'(want.last));
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request on either side.
    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no request accepted for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : run_test
        int len;
        int pick;
        hash_restart();

        // Directed: empty message twice in a row, byte extremes, a short text, bit patterns.
        queue_finish();
        queue_finish();
        queue_byte(8'h00);
        queue_finish();
        queue_byte(8'hFF);
        queue_finish();
        queue_byte(8'h61);
        queue_byte(8'h62);
        queue_byte(8'h63);
        queue_finish();
        queue_byte(8'h80);
        queue_byte(8'h7F);
        queue_byte(8'h01);
        queue_byte(8'hFE);
        queue_finish();
        queue_byte(8'h55);
        queue_byte(8'hAA);
        queue_finish();

        // Random messages, mostly short, some around the padding and block boundaries.
        while (total_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                case ($urandom_range(0, 8))
                    0: len = 0;
                    1: len = 55;
                    2: len = 56;
                    3: len = 57;
                    4: len = 63;
                    5: len = 64;
                    6: len = 65;
                    7: len = 119;
                    default: len = 120;
                endcase
            end
            else
            begin
                len = $urandom_range(0, 24);
            end
            queue_message(len);
        end

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        while (accepted_items != total_items)
            @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (digest_q.size() != 0)
            report_mismatch("digest words never delivered", 32'(digest_q.size()), 32'd0);
        $display("run covered %0d messages over %0d absorbed bytes, %0d digest words checked",
                 messages_hashed, bytes_absorbed, words_checked);
        $display("lengths spanned the empty message, both padding cases and multi-block input");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sha256bsh_pkg.sv
rtl/sha256bsh_ctrl.sv
rtl/sha256bsh_dp.sv
rtl/sha256_byte_stream_hasher_core.sv
sim/tb_top.sv
